// ----- hw/rtl/dip_pkg.sv -----
// Shared types and constants for the dotted IPv4 address normalizer.
// No dependencies; used by every module under hw/rtl.
package dip_pkg;

   localparam logic [11:0] OCTET_LIMIT = 12'd256;
   localparam logic [2:0]  DOTS_NEEDED = 3'd3;
   localparam logic [2:0]  DOTS_MAX    = 3'd4;

   typedef enum logic [1:0] {
      STATUS_NOT_IP  = 2'd0,
      STATUS_IP      = 2'd1,
      STATUS_ILLEGAL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      POS_START      = 2'd0,
      POS_AFTER_ZERO = 2'd1,
      POS_DIGITS     = 2'd2
   } pos_type;

   typedef enum logic [1:0] {
      RDX_DEC = 2'd0,
      RDX_OCT = 2'd1,
      RDX_HEX = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_BAD  = 2'd1,
      FAULT_OVER = 2'd2
   } fault_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] octet_a;
      logic [7:0] octet_b;
      logic [7:0] octet_c;
      logic [7:0] octet_d;
   } rsp_type;

   // Character classification handed from the decoder to the part parser.
   typedef struct packed {
      logic       legal;
      logic       is_dot;
      logic       is_zero;
      logic       is_x;
      logic       is_dec;
      logic       is_oct;
      logic       is_hex;
      logic [3:0] digit;
   } char_class_type;

endpackage

// ----- hw/rtl/dotted_ip_normalizer.sv -----
// Top level of the dotted IPv4 address normalizer: input register, character
// decoder, part parser and result register. Depends on dip_pkg,
// dip_char_decode and dip_part_parse.
//
// Takes host-name characters on req_ (valid/ready) and, for the
// character marked last, returns one transfer on rsp_ with a status and four
// octets. A character is held in the input register and parsed as it leaves
// it; the result of a last character is shown from the result register.
// Throughput is one character per cycle; it drops only while a finished
// result is held in the result register and the next last character is
// waiting behind it.
module dotted_ip_normalizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dip_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dip_pkg::rsp_type rsp_payload
);

   dip_pkg::req_type        req_ff;
   logic                    req_valid_ff, req_valid_in;
   dip_pkg::rsp_type        rsp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   dip_pkg::char_class_type cls;
   dip_pkg::rsp_type        result;
   logic                    out_free;
   logic                    step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid_ff && (!req_ff.last || out_free);
   assign req_ready = !req_valid_ff || step;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) begin
         req_valid_in = 1'b1;
      end else if (step) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step && req_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (step && req_ff.last) begin
         rsp_ff <= result;
      end
   end

   dip_char_decode u_decode (
      .ch  (req_ff.ch),
      .cls (cls)
   );

   dip_part_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .last   (req_ff.last),
      .cls    (cls),
      .result (result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_step_needs_item: assert property (@(posedge clock) disable iff (reset)
      step |-> req_valid_ff)
      else $error("parse step without a held character");

   a_last_needs_room: assert property (@(posedge clock) disable iff (reset)
      (step && req_ff.last) |-> out_free)
      else $error("result register overwritten");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      (step && req_ff.last) |=> rsp_valid_ff)
      else $error("result missing after last character");
`endif

endmodule

// ----- hw/rtl/dip_char_decode.sv -----
// Character classifier: legality, separators, prefix marks and digit value.
// Depends on dip_pkg.
module dip_char_decode (
   input  logic [7:0]              ch,
   output dip_pkg::char_class_type cls
);

   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SEVEN   = 8'h37;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_UP_X    = 8'h58;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_F    = 8'h66;
   localparam logic [7:0] CH_LO_X    = 8'h78;

   logic is_dec;
   logic is_lower;
   logic is_upper;
   logic is_x;
   logic is_dot;

   assign is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_lower = (ch >= CH_LO_A) && (ch <= CH_LO_F);
   assign is_upper = (ch >= CH_UP_A) && (ch <= CH_UP_F);
   assign is_x     = (ch == CH_LO_X) || (ch == CH_UP_X);
   assign is_dot   = (ch == CH_DOT);

   always_comb begin
      cls.legal   = is_dec | is_dot | is_x | is_lower | is_upper;
      cls.is_dot  = is_dot;
      cls.is_zero = (ch == CH_ZERO);
      cls.is_x    = is_x;
      cls.is_dec  = is_dec;
      cls.is_oct  = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
      cls.is_hex  = is_dec | is_lower | is_upper;
      // letters a-f / A-F have low nibble 1..6
      cls.digit   = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
   end

endmodule

// ----- hw/rtl/dip_part_parse.sv -----
// Per-part parse state: radix detection, digit accumulation, dot count,
// fault tracking and octet store; forms the result for the final character.
// Depends on dip_pkg.
module dip_part_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    last,
   input  dip_pkg::char_class_type cls,
   output dip_pkg::rsp_type        result
);

   logic [11:0]         value_ff,  value_in;
   dip_pkg::pos_type    pos_ff,    pos_in;
   dip_pkg::radix_type  radix_ff,  radix_in;
   logic [2:0]          dots_ff,   dots_in;
   logic                legal_ff,  legal_in;
   dip_pkg::fault_type  fault_ff,  fault_in;
   logic [3:0][7:0]     octet_ff,  octet_in;

   logic                take;
   logic                dig_ok;
   logic [11:0]         prod;
   logic [3:0][7:0]     fin_octet;
   dip_pkg::status_type status;

   always_comb begin
      value_in = value_ff;
      pos_in   = pos_ff;
      radix_in = radix_ff;
      dots_in  = dots_ff;
      legal_in = legal_ff & cls.legal;
      fault_in = fault_ff;
      octet_in = octet_ff;
      take     = 1'b0;
      dig_ok   = 1'b0;
      prod     = '0;

      if (cls.is_dot) begin
         if ((fault_ff == dip_pkg::FAULT_NONE) && (dots_ff < dip_pkg::DOTS_MAX)) begin
            octet_in[dots_ff[1:0]] = value_ff[7:0];
         end
         value_in = '0;
         pos_in   = dip_pkg::POS_START;
         radix_in = dip_pkg::RDX_DEC;
         if (dots_ff < dip_pkg::DOTS_MAX) begin
            dots_in = dots_ff + 3'd1;
         end
      end else if (fault_ff == dip_pkg::FAULT_NONE) begin
         case (pos_ff)
            dip_pkg::POS_START: begin
               if (cls.is_zero) begin
                  pos_in   = dip_pkg::POS_AFTER_ZERO;
                  radix_in = dip_pkg::RDX_OCT;
               end else begin
                  pos_in   = dip_pkg::POS_DIGITS;
                  radix_in = dip_pkg::RDX_DEC;
                  take     = 1'b1;
               end
            end
            dip_pkg::POS_AFTER_ZERO: begin
               pos_in = dip_pkg::POS_DIGITS;
               if (cls.is_x) begin
                  radix_in = dip_pkg::RDX_HEX;
               end else begin
                  radix_in = dip_pkg::RDX_OCT;
                  take     = 1'b1;
               end
            end
            default: begin
               take = 1'b1;
            end
         endcase
      end

      if (take) begin
         case (radix_in)
            dip_pkg::RDX_HEX: begin
               dig_ok = cls.is_hex;
               prod   = {value_ff[7:0], 4'd0} + {8'd0, cls.digit};
            end
            dip_pkg::RDX_OCT: begin
               dig_ok = cls.is_oct;
               prod   = {value_ff[8:0], 3'd0} + {8'd0, cls.digit};
            end
            default: begin
               dig_ok = cls.is_dec;
               prod   = {value_ff[8:0], 3'd0} + {value_ff[10:0], 1'b0}
                      + {8'd0, cls.digit};
            end
         endcase
         if (!dig_ok) begin
            fault_in = dip_pkg::FAULT_BAD;
         end else begin
            value_in = prod;
            if (prod >= dip_pkg::OCTET_LIMIT) begin
               fault_in = dip_pkg::FAULT_OVER;
            end
         end
      end
   end

   // final part closes at the last character
   always_comb begin
      fin_octet = octet_in;
      if ((fault_in == dip_pkg::FAULT_NONE) && (dots_in < dip_pkg::DOTS_MAX)) begin
         fin_octet[dots_in[1:0]] = value_in[7:0];
      end
      if (!legal_in || (dots_in != dip_pkg::DOTS_NEEDED)) begin
         status = dip_pkg::STATUS_NOT_IP;
      end else if (fault_in == dip_pkg::FAULT_OVER) begin
         status = dip_pkg::STATUS_ILLEGAL;
      end else if (fault_in == dip_pkg::FAULT_BAD) begin
         status = dip_pkg::STATUS_NOT_IP;
      end else begin
         status = dip_pkg::STATUS_IP;
      end
      result.status  = status;
      result.octet_a = (status == dip_pkg::STATUS_IP) ? fin_octet[0] : 8'd0;
      result.octet_b = (status == dip_pkg::STATUS_IP) ? fin_octet[1] : 8'd0;
      result.octet_c = (status == dip_pkg::STATUS_IP) ? fin_octet[2] : 8'd0;
      result.octet_d = (status == dip_pkg::STATUS_IP) ? fin_octet[3] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         value_ff <= '0;
         pos_ff   <= dip_pkg::POS_START;
         radix_ff <= dip_pkg::RDX_DEC;
         dots_ff  <= '0;
         legal_ff <= 1'b1;
         fault_ff <= dip_pkg::FAULT_NONE;
         octet_ff <= '0;
      end else if (step) begin
         value_ff <= value_in;
         pos_ff   <= pos_in;
         radix_ff <= radix_in;
         dots_ff  <= dots_in;
         legal_ff <= legal_in;
         fault_ff <= fault_in;
         octet_ff <= octet_in;
      end
   end

`ifndef SYNTHESIS
   a_dots_bound: assert property (@(posedge clock) disable iff (reset)
      dots_ff <= dip_pkg::DOTS_MAX)
      else $error("dot count past saturation");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      (fault_ff == dip_pkg::FAULT_NONE) |-> (value_ff < dip_pkg::OCTET_LIMIT))
      else $error("part value reached limit without fault");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && last) |=> (dots_ff == 3'd0) && (value_ff == 12'd0) && legal_ff
                         && (fault_ff == dip_pkg::FAULT_NONE))
      else $error("parse state not cleared after last character");
`endif

endmodule

// ----- tb/tb_dotted_ip_normalizer.sv -----
// Self-checking testbench for dotted_ip_normalizer: streams host names one
// character per transfer and checks every status/octet result against a
// cycle-free predictor kept in a scoreboard class. Depends on dip_pkg and dotted_ip_normalizer.
`timescale 1ns / 100ps

module tb_dotted_ip_normalizer;

   typedef logic [7:0] name_type[$];

   class address_scoreboard;
      logic [11:0]        part_value;
      dip_pkg::pos_type   part_pos;
      dip_pkg::radix_type part_rdx;
      logic [2:0]         dots;
      bit                 all_legal;
      dip_pkg::fault_type fault;
      logic [7:0]         octets[4];
      dip_pkg::rsp_type   pending_addresses[$];
      int                 errors;
      int                 n_ip;
      int                 n_illegal;
      int                 n_not_ip;
      int                 n_chars;

      function new();
         clear();
         errors    = 0;
         n_ip      = 0;
         n_illegal = 0;
         n_not_ip  = 0;
         n_chars   = 0;
      endfunction

      function void clear();
         part_value = '0;
         part_pos   = dip_pkg::POS_START;
         part_rdx   = dip_pkg::RDX_DEC;
         dots       = '0;
         all_legal  = 1'b1;
         fault      = dip_pkg::FAULT_NONE;
         foreach (octets[k]) octets[k] = '0;
      endfunction

      function bit is_legal(logic [7:0] c);
         return (c >= "0" && c <= "9") || c == "." || c == "x" || c == "X" ||
                (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      // -1 when c is not a digit of the radix
      function int digit_value(logic [7:0] c, dip_pkg::radix_type r);
         if (c >= "0" && c <= "9" && (r != dip_pkg::RDX_OCT || c <= "7"))
            return int'(c) - 48;
         if (r == dip_pkg::RDX_HEX && c >= "a" && c <= "f") return int'(c) - 87;
         if (r == dip_pkg::RDX_HEX && c >= "A" && c <= "F") return int'(c) - 55;
         return -1;
      endfunction

      function void add_digit(logic [7:0] c);
         int base;
         int d;
         int v;
         base = (part_rdx == dip_pkg::RDX_HEX) ? 16 :
                (part_rdx == dip_pkg::RDX_OCT) ? 8 : 10;
         d = digit_value(c, part_rdx);
         if (d < 0) begin
            fault = dip_pkg::FAULT_BAD;
            return;
         end
         v = int'(part_value) * base + d;
         part_value = v[11:0];
         if (part_value >= dip_pkg::OCTET_LIMIT) fault = dip_pkg::FAULT_OVER;
      endfunction

      function void close_part();
         if (fault == dip_pkg::FAULT_NONE && dots < dip_pkg::DOTS_MAX)
            octets[dots[1:0]] = part_value[7:0];
         part_value = '0;
         part_pos   = dip_pkg::POS_START;
         part_rdx   = dip_pkg::RDX_DEC;
      endfunction

      function void note_char(dip_pkg::req_type r);
         dip_pkg::rsp_type exp;
         n_chars++;
         if (!is_legal(r.ch)) all_legal = 1'b0;
         if (r.ch == ".") begin
            close_part();
            if (dots < dip_pkg::DOTS_MAX) dots++;
         end else if (fault == dip_pkg::FAULT_NONE) begin
            case (part_pos)
               dip_pkg::POS_START: begin
                  if (r.ch == "0") begin
                     part_pos = dip_pkg::POS_AFTER_ZERO;
                     part_rdx = dip_pkg::RDX_OCT;
                  end else begin
                     part_pos = dip_pkg::POS_DIGITS;
                     part_rdx = dip_pkg::RDX_DEC;
                     add_digit(r.ch);
                  end
               end
               dip_pkg::POS_AFTER_ZERO: begin
                  part_pos = dip_pkg::POS_DIGITS;
                  if (r.ch == "x" || r.ch == "X") begin
                     part_rdx = dip_pkg::RDX_HEX;
                  end else begin
                     part_rdx = dip_pkg::RDX_OCT;
                     add_digit(r.ch);
                  end
               end
               default: add_digit(r.ch);
            endcase
         end
         if (!r.last) return;
         close_part();
         if (!all_legal || dots != dip_pkg::DOTS_NEEDED)
            exp.status = dip_pkg::STATUS_NOT_IP;
         else if (fault == dip_pkg::FAULT_OVER)
            exp.status = dip_pkg::STATUS_ILLEGAL;
         else if (fault == dip_pkg::FAULT_BAD)
            exp.status = dip_pkg::STATUS_NOT_IP;
         else
            exp.status = dip_pkg::STATUS_IP;
         if (exp.status == dip_pkg::STATUS_IP) begin
            exp.octet_a = octets[0];
            exp.octet_b = octets[1];
            exp.octet_c = octets[2];
            exp.octet_d = octets[3];
            n_ip++;
         end else begin
            exp.octet_a = '0;
            exp.octet_b = '0;
            exp.octet_c = '0;
            exp.octet_d = '0;
            if (exp.status == dip_pkg::STATUS_ILLEGAL) n_illegal++;
            else n_not_ip++;
         end
         pending_addresses.insert(pending_addresses.size(), exp);
         clear();
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_result(dip_pkg::rsp_type got);
         dip_pkg::rsp_type exp;
         if (pending_addresses.size() == 0) begin
            report($sformatf("unexpected result transfer %p", got));
            return;
         end
         exp = pending_addresses.pop_front();
         if (got.status !== exp.status)
            report($sformatf("status got %0d exp %0d", got.status, exp.status));
         if (got.octet_a !== exp.octet_a)
            report($sformatf("octet_a got %0d exp %0d", got.octet_a, exp.octet_a));
         if (got.octet_b !== exp.octet_b)
            report($sformatf("octet_b got %0d exp %0d", got.octet_b, exp.octet_b));
         if (got.octet_c !== exp.octet_c)
            report($sformatf("octet_c got %0d exp %0d", got.octet_c, exp.octet_c));
         if (got.octet_d !== exp.octet_d)
            report($sformatf("octet_d got %0d exp %0d", got.octet_d, exp.octet_d));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dip_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   dip_pkg::rsp_type rsp_payload;

   int req_idle_pct;
   int rsp_idle_pct;
   int chars_sent;
   int names_sent;

   address_scoreboard sb = new();

   dotted_ip_normalizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = !reset && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_char(req_payload);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   // called and returns at a falling edge, so names can follow back to back
   task send_name(name_type name);
      foreach (name[i]) begin
         while ($urandom_range(99) < req_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid   = 1'b1;
         req_payload = '{ch: name[i], last: (i == name.size() - 1)};
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         chars_sent++;
      end
      names_sent++;
      req_valid = 1'b0;
   endtask

   task automatic send_text(string s);
      name_type q;
      for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
      send_name(q);
   endtask

   task wait_drained();
      while (sb.pending_addresses.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void append_text(ref name_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
   endfunction

   function automatic void append_part(ref name_type q);
      int    r;
      int    v;
      string lead;
      r = $urandom_range(99);
      v = ($urandom_range(99) < 85) ? $urandom_range(255) : $urandom_range(256, 4095);
      lead = "";
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) lead = {lead, "0"};
      if (r < 5) return;
      else if (r < 10) append_text(q, "0");
      else if (r < 13) append_text(q, $urandom_range(1) ? "0x" : "0X");
      else if (r < 50) append_text(q, $sformatf("%0d", v));
      else if (r < 70) append_text(q, $sformatf("0%s%0o", lead, v));
      else if ($urandom_range(1)) append_text(q, $sformatf("0x%s%0x", lead, v));
      else append_text(q, $sformatf("0X%s%0X", lead, v));
   endfunction

   function automatic name_type random_name();
      name_type q;
      int       kind;
      int       parts;
      string    legal_set;
      legal_set = "0123456789abcdefABCDEFxX.";
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 10)) q.insert(q.size(), 8'($urandom_range(255)));
         return q;
      end
      parts = (kind < 80 || kind >= 90) ? 4 : $urandom_range(1, 6);
      for (int p = 0; p < parts; p++) begin
         if (p > 0) q.insert(q.size(), ".");
         append_part(q);
      end
      if (q.size() == 0) q.insert(q.size(), "0");
      if (kind >= 90) begin
         if ($urandom_range(1))
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
         else
            q[$urandom_range(q.size() - 1)] = legal_set[$urandom_range(legal_set.len() - 1)];
      end
      return q;
   endfunction

   initial begin
      string directed[] = '{
         "0.0.0.0", "255.255.255.255", "0xff.0377.10.0Xab", ".0x.0.00",
         "0x000ff.000377.0.09", "256.1.1.1", "1.2.3.0400", "0x100.1.1.1",
         "1.2.3", "1.2.3.4.5", "....", "1.2.3.08", "a.b.c.d", "1.2.3.4g",
         "999.1.1.1z", "256.x.1.1", "1.0xg.3.4", "1", "."
      };
      name_type q;
      int       phase_target;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      chars_sent   = 0;
      names_sent   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_text(directed[i]);
      // zero byte and bytes above 127 are illegal characters
      q = '{"1", ".", "2", ".", "3", ".", 8'h00};
      send_name(q);
      q = '{"1", ".", 8'hff, ".", "3", ".", "4"};
      send_name(q);
      q = '{8'h80};
      send_name(q);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 83 : 0;
         rsp_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 24 : 0;
         phase_target = chars_sent + 667;
         while (chars_sent < phase_target) send_name(random_name());
         // hold off the sender until the result side is empty
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (sb.pending_addresses.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending_addresses.size()));
      $display("Sent %0d host names, %0d characters, under three idle/stall mixes.",
               names_sent, chars_sent);
      $display("Results: %0d valid, %0d over-range, %0d rejected.",
               sb.n_ip, sb.n_illegal, sb.n_not_ip);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TIMEOUT: run did not complete");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
